// File: rtl/core/spsm_pkg.sv
// ----------------------------------------------------------------------------
// Slotted page space manager package
// Shared types, codes and constants for the slot directory block.
// ----------------------------------------------------------------------------
package spsm_pkg;

  localparam int unsigned PageBytesDef   = 4096;
  localparam int unsigned HeaderBytesDef = 12;
  localparam int unsigned EntryBytes     = 4;
  localparam int unsigned MaxSlotsDef    = 1024;
  localparam logic [11:0] MaxRecordReset = 12'd4084;

  localparam logic [2:0] OpClear  = 3'd0;
  localparam logic [2:0] OpInsert = 3'd1;
  localparam logic [2:0] OpGet    = 3'd2;
  localparam logic [2:0] OpUpdate = 3'd3;
  localparam logic [2:0] OpDelete = 3'd4;
  localparam logic [2:0] OpNext   = 3'd5;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoSpace  = 3'd1;
  localparam logic [2:0] StAbsent   = 3'd2;
  localparam logic [2:0] StEmpty    = 3'd3;
  localparam logic [2:0] StTooLarge = 3'd4;

  localparam logic [0:0] RegMaxRecord = 1'd0;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  slot;
    logic [11:0] record_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  result_slot;
    logic [11:0] record_offset;
    logic [11:0] result_length;
    logic [12:0] free_space;
    logic [12:0] compactable_space;
    logic [10:0] live_records;
  } out_item_t;

endpackage

// File: rtl/core/spsm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module spsm_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: rtl/core/slotted_page_space_manager_unit.sv
// ----------------------------------------------------------------------------
// Slotted page space manager
// Slot directory of one page: placement, free space and compaction.
// ----------------------------------------------------------------------------
// Each item is handled by a sequencer over one directory RAM with a single
// port, one entry touched per cycle. Insert and next occupied walk the
// directory entry by entry. An update that must compact walks every used
// slot, reading, waiting and writing back each entry in turn. The result is
// held in an output register; the block is not ready until it is taken.
module slotted_page_space_manager_unit
  import spsm_pkg::*;
#(
  parameter int unsigned HeaderBytes = HeaderBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spsm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spsm_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned PageBytes = PageBytesDef;
  localparam int unsigned MaxSlots  = MaxSlotsDef;
  localparam int unsigned Aw = $clog2(MaxSlots);
  localparam int unsigned Cw = Aw + 1;
  localparam int unsigned Bw = $clog2(PageBytes) + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_EVAL, S_SCAN, S_PACK_RD, S_PACK_WAIT, S_PACK_WR,
    S_FIN, S_OUT
  } state_e;

  state_e state_q;
  in_item_t item_q;
  out_item_t res_q;
  logic [11:0] max_rec_q;
  logic [Cw-1:0] used_q, live_q, idx_q;
  logic [Bw-1:0] start_q, bytes_q, old_len_q;
  logic [2:0] st_q;
  logic pack_done_q;

  logic ram_we;
  logic [Aw-1:0] ram_addr;
  logic [23:0] ram_wdata, ram_rdata;
  logic [11:0] rd_off, rd_len;

  assign rd_off = ram_rdata[23:12];
  assign rd_len = ram_rdata[11:0];

  spsm_ram #(.Width(24), .Depth(MaxSlots)) u_dir (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  logic [Bw-1:0] dir_end, free_b, used_b, len_ext, page_b;
  assign page_b  = Bw'(PageBytes);
  assign dir_end = Bw'(HeaderBytes) + Bw'({used_q, 2'b00});
  assign free_b  = (start_q > dir_end) ? start_q - dir_end : '0;
  assign used_b  = dir_end + bytes_q;
  assign len_ext = Bw'(item_q.record_length);

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1:1] == 1'(RegMaxRecord));
  assign prdata = (paddr[1:1] == 1'(RegMaxRecord)) ? {20'd0, max_rec_q} : '0;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_item_o  = res_q;

  logic present;
  assign present = (Cw'(item_q.slot) < used_q) && (rd_off != '0);

  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx_q[Aw-1:0];
    ram_wdata = '0;
    unique case (state_q)
      S_EVAL: begin
        if (present && item_q.operation == OpDelete) begin
          ram_we = 1'b1;
        end else if (present && item_q.operation == OpUpdate &&
                     item_q.record_length != '0 &&
                     item_q.record_length <= max_rec_q) begin
          ram_we = 1'b1;
          if (len_ext <= Bw'(rd_len)) begin
            ram_wdata = {rd_off, item_q.record_length};
          end else if (free_b >= len_ext) begin
            ram_wdata = {12'(start_q - len_ext), item_q.record_length};
          end
        end
      end
      S_SCAN: begin
        if (item_q.operation == OpInsert && (idx_q == used_q || rd_off == '0)) begin
          ram_we = (idx_q < used_q) ? (free_b >= len_ext) :
                   (free_b >= len_ext + Bw'(EntryBytes)) && (used_q < Cw'(MaxSlots));
          ram_wdata = {12'(start_q - len_ext), item_q.record_length};
        end
      end
      S_PACK_WR: begin
        ram_we = rd_off != '0;
        ram_wdata = {12'(start_q - Bw'(rd_len)), rd_len};
      end
      S_FIN: begin
        ram_we = pack_done_q;
        ram_addr = item_q.slot[Aw-1:0];
        ram_wdata = (free_b >= len_ext) ?
                    {12'(start_q - len_ext), item_q.record_length} :
                    {12'(start_q - old_len_q), 12'(old_len_q)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      max_rec_q <= MaxRecordReset;
      used_q <= '0;
      live_q <= '0;
      start_q <= Bw'(PageBytes);
      bytes_q <= '0;
      idx_q <= '0;
      st_q <= StOk;
      pack_done_q <= 1'b0;
      old_len_q <= '0;
      item_q <= '0;
      res_q <= '0;
    end else begin
      if (cfg_wr) begin
        max_rec_q <= pwdata[11:0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_item_i;
            st_q <= StOk;
            res_q.result_slot <= '0;
            res_q.record_offset <= '0;
            res_q.result_length <= '0;
            idx_q <= Cw'(in_item_i.slot);
            unique case (in_item_i.operation)
              OpClear: begin
                used_q <= '0; live_q <= '0; bytes_q <= '0;
                start_q <= Bw'(PageBytes);
                state_q <= S_FIN;
              end
              OpInsert: begin
                idx_q <= '0;
                if (in_item_i.record_length == '0) begin
                  st_q <= StEmpty; state_q <= S_FIN;
                end else if (in_item_i.record_length > max_rec_q) begin
                  st_q <= StTooLarge; state_q <= S_FIN;
                end else begin
                  state_q <= S_RD;
                end
              end
              OpGet, OpUpdate, OpDelete, OpNext: state_q <= S_RD;
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_RD: begin
          state_q <= (item_q.operation == OpInsert || item_q.operation == OpNext) ?
                     S_SCAN : S_WAIT;
          if (item_q.operation == OpNext && idx_q >= used_q) begin
            st_q <= StAbsent;
            res_q.result_slot <= item_q.slot;
            state_q <= S_FIN;
          end
        end
        S_WAIT: state_q <= S_EVAL;
        S_EVAL: begin
          res_q.result_slot <= item_q.slot;
          state_q <= S_FIN;
          if (!present) begin
            st_q <= StAbsent;
          end else begin
            res_q.record_offset <= rd_off;
            res_q.result_length <= rd_len;
            if (item_q.operation == OpDelete) begin
              bytes_q <= bytes_q - Bw'(rd_len);
              live_q <= live_q - 1'b1;
            end else if (item_q.operation == OpUpdate) begin
              if (item_q.record_length == '0) begin
                st_q <= StEmpty;
              end else if (item_q.record_length > max_rec_q) begin
                st_q <= StTooLarge;
              end else if (len_ext <= Bw'(rd_len)) begin
                res_q.result_length <= item_q.record_length;
                bytes_q <= bytes_q - Bw'(rd_len) + len_ext;
              end else if (free_b >= len_ext) begin
                start_q <= start_q - len_ext;
                res_q.record_offset <= 12'(start_q - len_ext);
                res_q.result_length <= item_q.record_length;
                bytes_q <= bytes_q - Bw'(rd_len) + len_ext;
              end else begin
                old_len_q <= Bw'(rd_len);
                bytes_q <= bytes_q - Bw'(rd_len);
                start_q <= Bw'(PageBytes);
                idx_q <= '0;
                pack_done_q <= 1'b0;
                state_q <= (used_q == '0) ? S_FIN : S_PACK_RD;
              end
            end
          end
        end
        S_SCAN: begin
          state_q <= S_RD;
          if (item_q.operation == OpInsert) begin
            if (idx_q == used_q || rd_off == '0) begin
              state_q <= S_FIN;
              if (ram_we) begin
                if (idx_q == used_q) used_q <= used_q + 1'b1;
                start_q <= start_q - len_ext;
                live_q <= live_q + 1'b1;
                bytes_q <= bytes_q + len_ext;
                res_q.result_slot <= idx_q[9:0];
                res_q.record_offset <= 12'(start_q - len_ext);
                res_q.result_length <= item_q.record_length;
              end else begin
                st_q <= StNoSpace;
              end
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else begin
            if (rd_off != '0) begin
              res_q.result_slot <= idx_q[9:0];
              res_q.record_offset <= rd_off;
              res_q.result_length <= rd_len;
              state_q <= S_FIN;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_PACK_RD: state_q <= S_PACK_WAIT;
        S_PACK_WAIT: state_q <= S_PACK_WR;
        S_PACK_WR: begin
          if (rd_off != '0 && idx_q != Cw'(item_q.slot)) begin
            start_q <= start_q - Bw'(rd_len);
          end
          if (idx_q + 1'b1 >= used_q) begin
            pack_done_q <= 1'b1;
            state_q <= S_FIN;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_PACK_RD;
          end
        end
        S_FIN: begin
          if (pack_done_q) begin
            pack_done_q <= 1'b0;
            res_q.result_slot <= item_q.slot;
            res_q.record_offset <= ram_wdata[23:12];
            res_q.result_length <= ram_wdata[11:0];
            start_q <= Bw'(ram_wdata[23:12]);
            bytes_q <= bytes_q + Bw'(ram_wdata[11:0]);
            if (free_b < len_ext) st_q <= StNoSpace;
            state_q <= S_FIN;
          end else begin
            res_q.status <= st_q;
            res_q.free_space <= 13'(free_b);
            res_q.compactable_space <= (page_b > used_b) ? 13'(page_b - used_b) : '0;
            res_q.live_records <= 11'(live_q);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= used_q) else $error("live count above slots used");
  a_ready_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_start_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q <= page_b) else $error("data start beyond page");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= Cw'(MaxSlots)) else $error("slots used beyond directory");

endmodule

// File: tb/slotted_page_space_manager_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slotted page space manager regression
// Drives directed and random directory operations through the item handshake,
// predicts results from a shadow directory unless a directed row gives them
// and compares them field by field; record size limit and idling are varied.
// ----------------------------------------------------------------------------
module slotted_page_space_manager_unit_test;
  import spsm_pkg::*;

  localparam int unsigned PageSz  = 4096;
  localparam int unsigned HdrSz   = 12;
  localparam int unsigned SlotCap = 1024;
  localparam int unsigned StallLimit = 60000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned shadow_off [SlotCap];
  int unsigned shadow_len [SlotCap];
  int unsigned slots_used;
  int unsigned live_cnt;
  int unsigned data_top;
  int unsigned live_sum;
  int unsigned max_len;

  out_item_t   pending_results[$];
  row_t        directed_rows[$];
  int          fail_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          hold_left;
  int unsigned quiet_cycles;

  slotted_page_space_manager_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned dir_end();
    return HdrSz + EntryBytes * slots_used;
  endfunction

  function automatic int unsigned free_now();
    return data_top > dir_end() ? data_top - dir_end() : 0;
  endfunction

  function automatic int unsigned packable_now();
    return PageSz > dir_end() + live_sum ? PageSz - dir_end() - live_sum : 0;
  endfunction

  function automatic void wipe_page();
    for (int i = 0; i < SlotCap; i++) begin
      shadow_off[i] = 0;
      shadow_len[i] = 0;
    end
    slots_used = 0;
    live_cnt   = 0;
    data_top   = PageSz;
    live_sum   = 0;
  endfunction

  function automatic int unsigned carve(int unsigned n);
    data_top = data_top - n;
    return data_top;
  endfunction

  function automatic out_item_t place_record(in_item_t it);
    out_item_t   r;
    int unsigned s;
    int unsigned n;
    int unsigned pick;
    int unsigned need;
    int unsigned old_n;
    bit          present;
    r = '0;
    s = 32'(it.slot);
    n = 32'(it.record_length);
    present = s < slots_used && shadow_off[s] != 0;
    case (it.operation)
      OpClear: wipe_page();
      OpInsert: begin
        if (n == 0) begin
          r.status = StEmpty;
        end else if (n > max_len) begin
          r.status = StTooLarge;
        end else begin
          pick = slots_used;
          for (int i = 0; i < slots_used; i++) begin
            if (shadow_off[i] == 0) begin
              pick = i;
              break;
            end
          end
          need = (pick == slots_used) ? n + EntryBytes : n;
          if (free_now() < need || pick >= SlotCap) begin
            r.status = StNoSpace;
          end else begin
            if (pick == slots_used) slots_used++;
            shadow_off[pick] = carve(n);
            shadow_len[pick] = n;
            live_cnt++;
            live_sum += n;
            r.result_slot   = 10'(pick);
            r.record_offset = 12'(shadow_off[pick]);
            r.result_length = 12'(n);
          end
        end
      end
      OpGet, OpUpdate, OpDelete: begin
        r.result_slot = 10'(s);
        if (!present) begin
          r.status = StAbsent;
        end else if (it.operation == OpGet) begin
          r.record_offset = 12'(shadow_off[s]);
          r.result_length = 12'(shadow_len[s]);
        end else if (it.operation == OpDelete) begin
          r.record_offset = 12'(shadow_off[s]);
          r.result_length = 12'(shadow_len[s]);
          live_sum -= shadow_len[s];
          live_cnt--;
          shadow_off[s] = 0;
          shadow_len[s] = 0;
        end else if (n == 0 || n > max_len) begin
          r.status = (n == 0) ? StEmpty : StTooLarge;
          r.record_offset = 12'(shadow_off[s]);
          r.result_length = 12'(shadow_len[s]);
        end else begin
          old_n = shadow_len[s];
          if (n <= old_n) begin
            shadow_len[s] = n;
          end else if (free_now() >= n) begin
            shadow_off[s] = carve(n);
            shadow_len[s] = n;
          end else begin
            shadow_off[s] = 0;
            shadow_len[s] = 0;
            data_top = PageSz;
            for (int i = 0; i < slots_used; i++) begin
              if (shadow_off[i] != 0) shadow_off[i] = carve(shadow_len[i]);
            end
            if (free_now() >= n) begin
              shadow_off[s] = carve(n);
              shadow_len[s] = n;
            end else begin
              shadow_off[s] = carve(old_n);
              shadow_len[s] = old_n;
              r.status = StNoSpace;
            end
          end
          live_sum = live_sum - old_n + shadow_len[s];
          r.record_offset = 12'(shadow_off[s]);
          r.result_length = 12'(shadow_len[s]);
        end
      end
      OpNext: begin
        r.status = StAbsent;
        r.result_slot = 10'(s);
        for (int i = s; i < slots_used; i++) begin
          if (shadow_off[i] != 0) begin
            r.status = StOk;
            r.result_slot = 10'(i);
            r.record_offset = 12'(shadow_off[i]);
            r.result_length = 12'(shadow_len[i]);
            break;
          end
        end
      end
      default: ;
    endcase
    r.free_space        = 13'(free_now());
    r.compactable_space = 13'(packable_now());
    r.live_records      = 11'(live_cnt);
    return r;
  endfunction

  function automatic in_item_t make_item(logic [2:0] op, int unsigned s, int unsigned n);
    in_item_t it;
    it.operation     = op;
    it.slot          = 10'(s);
    it.record_length = 12'(n);
    return it;
  endfunction

  function automatic void add_row(logic [2:0] op, int unsigned s, int unsigned n);
    row_t rw;
    rw.item   = make_item(op, s, n);
    rw.typed  = 1'b0;
    rw.result = '0;
    directed_rows = {directed_rows, rw};
  endfunction

  function automatic void add_typed(logic [2:0] op, int unsigned s, int unsigned n,
                                    logic [2:0] st, int unsigned rs, int unsigned fr,
                                    int unsigned cp, int unsigned lv);
    row_t rw;
    rw.item   = make_item(op, s, n);
    rw.typed  = 1'b1;
    rw.result = '0;
    rw.result.status            = st;
    rw.result.result_slot       = 10'(rs);
    rw.result.free_space        = 13'(fr);
    rw.result.compactable_space = 13'(cp);
    rw.result.live_records      = 11'(lv);
    directed_rows = {directed_rows, rw};
  endfunction

  function automatic in_item_t random_item();
    int unsigned r;
    int unsigned top;
    logic [2:0]  op;
    int unsigned s;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 3) op = OpClear;
    else if (r < 40) op = OpInsert;
    else if (r < 55) op = OpGet;
    else if (r < 75) op = OpUpdate;
    else if (r < 88) op = OpDelete;
    else if (r < 96) op = OpNext;
    else op = 3'($urandom_range(7, 6));
    top = slots_used + 1 > SlotCap - 1 ? SlotCap - 1 : slots_used + 1;
    s = ($urandom_range(99) < 80) ? $urandom_range(top) : $urandom_range(SlotCap - 1);
    r = $urandom_range(99);
    if (r < 70) n = $urandom_range(400, 1);
    else if (r < 80) n = 0;
    else n = $urandom_range(4095);
    return make_item(op, s, n);
  endfunction

  task automatic offer(in_item_t it, row_t rw, bit typed);
    int gap;
    out_item_t predicted;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = place_record(it);
    if (typed) predicted = rw.result;
    pending_results = {pending_results, predicted};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_max_len(int unsigned v);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 2'(RegMaxRecord) << 2;
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    max_len = v & 12'hFFF;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[11:0] != 12'(max_len)) begin
      $error("max_record_size readback: expected %0d, got %0d", max_len, prdata[11:0]);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_phase(int count, int s_pct, int r_pct, bit pressure);
    row_t unused;
    unused = '{default: '0};
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (pressure) hold_req = 1'b1;
    for (int k = 0; k < count; k++) offer(random_item(), unused, 1'b0);
    drain();
  endtask

  task automatic field_check(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req) begin
      out_ready_i <= 1'b0;
      hold_req    <= 1'b0;
      hold_left   <= 400;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        fail_cnt++;
      end else begin
        e = pending_results.pop_front();
        field_check("status", e.status, out_item_o.status);
        field_check("result_slot", e.result_slot, out_item_o.result_slot);
        field_check("record_offset", e.record_offset, out_item_o.record_offset);
        field_check("result_length", e.result_length, out_item_o.result_length);
        field_check("free_space", e.free_space, out_item_o.free_space);
        field_check("compactable_space", e.compactable_space, out_item_o.compactable_space);
        field_check("live_records", e.live_records, out_item_o.live_records);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("slotted_page_space_manager_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    out_ready_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_cnt      = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    quiet_cycles  = 0;
    send_idle_pct = 9;
    recv_idle_pct = 82;
    max_len       = MaxRecordReset;
    wipe_page();

    add_typed(OpGet, 0, 0, StAbsent, 0, 4084, 4084, 0);
    add_typed(OpInsert, 5, 0, StEmpty, 0, 4084, 4084, 0);
    add_typed(OpInsert, 0, 4095, StTooLarge, 0, 4084, 4084, 0);
    add_typed(OpNext, 0, 0, StAbsent, 0, 4084, 4084, 0);
    add_typed(3'd6, 1023, 4095, StOk, 0, 4084, 4084, 0);
    add_typed(3'd7, 0, 0, StOk, 0, 4084, 4084, 0);
    add_row(OpInsert, 0, 100);
    add_row(OpInsert, 0, 200);
    add_row(OpInsert, 0, 300);
    add_row(OpUpdate, 1, 50);
    add_row(OpUpdate, 0, 150);
    add_row(OpDelete, 1, 0);
    add_row(OpNext, 1, 0);
    add_row(OpInsert, 0, 20);
    add_row(OpGet, 1023, 0);
    add_row(OpUpdate, 1023, 10);
    add_row(OpDelete, 1023, 0);
    add_row(OpUpdate, 0, 0);
    add_row(OpUpdate, 0, 4095);
    add_row(OpInsert, 0, 3000);
    add_row(OpUpdate, 3, 3300);
    add_row(OpUpdate, 2, 3900);
    add_row(OpClear, 0, 0);
    add_row(OpInsert, 0, 4080);
    add_row(OpInsert, 0, 1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    set_max_len(MaxRecordReset);
    foreach (directed_rows[k]) begin
      offer(directed_rows[k].item, directed_rows[k], directed_rows[k].typed);
    end
    drain();

    set_max_len(4095);
    random_phase(190, 9, 82, 1'b0);
    set_max_len(1);
    random_phase(60, 82, 9, 1'b0);
    set_max_len($urandom_range(4095, 200));
    random_phase(180, 82, 9, 1'b1);
    set_max_len(MaxRecordReset);
    random_phase(130, 0, 0, 1'b0);

    if (fail_cnt == 0) begin
      $display("slotted_page_space_manager_unit regression: pass");
    end else begin
      $display("slotted_page_space_manager_unit regression: fail");
    end
    $finish;
  end

  final begin
    if (pending_results.size() != 0) $error("expectations left over at end");
  end

endmodule
